// ===== src/snf_pkg.sv =====
// shared types and constants of the serial nor flash device model
package snf_pkg;

  // default geometry
  localparam int unsigned ADDR_BITS_DEF    = 16;
  localparam int unsigned PAGE_BYTES_DEF   = 256;
  localparam int unsigned SECTOR_BYTES_DEF = 4096;

  // field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned FADDR_W   = 24;
  localparam int unsigned TICK_W    = 20;
  localparam int unsigned COUNT_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 20;

  // item commands
  localparam logic [CMD_W-1:0] CMD_BYTE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;

  // opcodes
  localparam logic [BYTE_W-1:0] OP_READ    = 8'h03;
  localparam logic [BYTE_W-1:0] OP_WREN    = 8'h06;
  localparam logic [BYTE_W-1:0] OP_STATUS  = 8'h05;
  localparam logic [BYTE_W-1:0] OP_ERASE   = 8'h20;
  localparam logic [BYTE_W-1:0] OP_PROGRAM = 8'h02;
  localparam logic [BYTE_W-1:0] OP_IDENT   = 8'h90;

  // bus idle value, also the erased byte
  localparam logic [BYTE_W-1:0] BYTE_IDLE = 8'hFF;

  // byte positions in a frame: the opcode, the start of the data phase and the last counted position
  localparam logic [COUNT_W-1:0] POS_OPCODE = 3'd0;
  localparam logic [COUNT_W-1:0] POS_DATA   = 3'd4;
  localparam logic [COUNT_W-1:0] POS_MAX    = 3'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MANUFACTURER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROG_TICKS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE_TICKS  = 2'd3;

  // configuration reset values
  localparam logic [BYTE_W-1:0] MANUFACTURER_RST = 8'hEF;
  localparam logic [BYTE_W-1:0] DEVICE_RST       = 8'h16;
  localparam logic [TICK_W-1:0] PROG_TICKS_RST   = '0;
  localparam logic [TICK_W-1:0] ERASE_TICKS_RST  = '0;

  // controller to datapath
  typedef struct packed {
    logic take;     // item accepted this cycle
    logic rd_done;  // array read data is ready for the result
    logic prog_wr;  // write the programmed byte back
    logic clr_wr;   // clearing pass write
    logic ers_wr;   // sector erase write
  } snf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_read;    // current item is a read data byte
    logic go_prog;    // current item is a program data byte
    logic go_erase;   // current item ends an erase frame
    logic sweep_last; // last address of the running sweep
    logic out_busy;   // result register stays full this cycle
  } snf_stat_t;

endpackage

// ===== src/snf_if.sv =====
// item channels of the flash device model

// input channel: one spi event per item
interface snf_in_if;
  logic                         valid;
  logic                         ready;
  logic [snf_pkg::CMD_W-1:0]    command;
  logic [snf_pkg::BYTE_W-1:0]   mosi_byte;

  modport source (output valid, command, mosi_byte, input ready);
  modport sink (input valid, command, mosi_byte, output ready);
endinterface

// output channel: one byte to the host per item
interface snf_out_if;
  logic                         valid;
  logic                         ready;
  logic [snf_pkg::BYTE_W-1:0]   miso_byte;

  modport source (output valid, miso_byte, input ready);
  modport sink (input valid, miso_byte, output ready);
endinterface

// ===== src/snf_ram.sv =====
// generic single write port ram with registered read
module snf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/snf_ctrl.sv =====
// controller state machine of the flash device model
module snf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  snf_pkg::snf_stat_t stat,
  output snf_pkg::snf_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_PROG  = 5'b01000,
    ST_ERASE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;

  // items are taken only in idle with room for a result
  assign in_ready = (state == ST_IDLE) && !stat.out_busy;
  assign take     = in_valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (take && stat.go_read) begin
          state_next = ST_READ;
        end else if (take && stat.go_prog) begin
          state_next = ST_PROG;
        end else if (take && stat.go_erase) begin
          state_next = ST_ERASE;
        end
      end
      ST_READ:  state_next = ST_IDLE;
      ST_PROG:  state_next = ST_IDLE;
      ST_ERASE: begin
        if (stat.sweep_last) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // commands to the datapath
  always_comb begin
    cmd         = '0;
    cmd.take    = take;
    cmd.rd_done = (state == ST_READ);
    cmd.prog_wr = (state == ST_PROG);
    cmd.clr_wr  = (state == ST_CLEAR);
    cmd.ers_wr  = (state == ST_ERASE);
  end

endmodule

// ===== src/snf_dp.sv =====
// datapath of the flash device model: frame state, registers, array, result
module snf_dp #(
  parameter int unsigned ADDR_BITS    = snf_pkg::ADDR_BITS_DEF,
  parameter int unsigned PAGE_BYTES   = snf_pkg::PAGE_BYTES_DEF,
  parameter int unsigned SECTOR_BYTES = snf_pkg::SECTOR_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  snf_pkg::snf_cmd_t                cmd,
  output snf_pkg::snf_stat_t               stat,
  input  logic [snf_pkg::CMD_W-1:0]        command,
  input  logic [snf_pkg::BYTE_W-1:0]       mosi_byte,
  input  logic                             cfg_we,
  input  logic [snf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [snf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [snf_pkg::BYTE_W-1:0]       miso_byte
);

  localparam int unsigned DEPTH     = 1 << ADDR_BITS;
  localparam int unsigned PAGE_BITS = $clog2(PAGE_BYTES);
  localparam int unsigned SECT_BITS = $clog2(SECTOR_BYTES);
  localparam int unsigned BASE_W    = ADDR_BITS - SECT_BITS;
  localparam int unsigned FW        = snf_pkg::FADDR_W;
  localparam int unsigned BW        = snf_pkg::BYTE_W;

  // frame state
  logic [BW-1:0]                  opcode;
  logic [snf_pkg::COUNT_W-1:0]    count;
  logic [FW-1:0]                  address;
  logic                           latch;
  logic                           accepted;
  logic [snf_pkg::TICK_W-1:0]     busy;

  // configuration
  logic [BW-1:0]                  manufacturer;
  logic [BW-1:0]                  device;
  logic [snf_pkg::TICK_W-1:0]     prog_ticks;
  logic [snf_pkg::TICK_W-1:0]     erase_ticks;

  // array access
  logic [ADDR_BITS-1:0]           mem_addr;
  logic [BW-1:0]                  prog_byte;
  logic [BASE_W-1:0]              erase_base;
  logic [ADDR_BITS-1:0]           sweep_cnt;
  logic                           ram_we;
  logic [ADDR_BITS-1:0]           ram_waddr;
  logic [BW-1:0]                  ram_wdata;
  logic [BW-1:0]                  ram_rdata;

  // decode
  logic                           is_byte;
  logic                           is_release;
  logic                           is_tick;
  logic                           busy_now;
  logic                           op_ok;
  logic                           addr_op;
  logic                           data_pos;
  logic                           byte_load;
  logic [BW-1:0]                  byte_resp;

  assign is_byte    = (command == snf_pkg::CMD_BYTE);
  assign is_release = (command == snf_pkg::CMD_RELEASE);
  assign is_tick    = (command == snf_pkg::CMD_TICK);
  assign busy_now   = (busy != '0);
  assign data_pos   = (count >= snf_pkg::POS_DATA);
  assign addr_op    = accepted && (opcode != snf_pkg::OP_STATUS)
                      && (opcode != snf_pkg::OP_WREN);

  // acceptance of a frame by its opcode
  always_comb begin
    case (mosi_byte)
      snf_pkg::OP_STATUS:  op_ok = 1'b1;
      snf_pkg::OP_READ,
      snf_pkg::OP_WREN,
      snf_pkg::OP_IDENT:   op_ok = !busy_now;
      snf_pkg::OP_PROGRAM,
      snf_pkg::OP_ERASE:   op_ok = !busy_now && latch;
      default:             op_ok = 1'b0;
    endcase
  end

  // status to the controller
  always_comb begin
    stat            = '0;
    stat.go_read    = is_byte && accepted && data_pos && (opcode == snf_pkg::OP_READ);
    stat.go_prog    = is_byte && accepted && data_pos && (opcode == snf_pkg::OP_PROGRAM);
    stat.go_erase   = is_release && accepted && data_pos && (opcode == snf_pkg::OP_ERASE);
    stat.sweep_last = cmd.clr_wr ? (&sweep_cnt) : (&sweep_cnt[SECT_BITS-1:0]);
    stat.out_busy   = out_valid && !out_ready;
  end

  // immediate answer to a byte
  always_comb begin
    byte_resp = snf_pkg::BYTE_IDLE;
    if (count == snf_pkg::POS_OPCODE || !accepted) begin
      byte_resp = snf_pkg::BYTE_IDLE;
    end else if (opcode == snf_pkg::OP_STATUS) begin
      byte_resp = {{(BW-2){1'b0}}, latch, busy_now};
    end else if (data_pos && opcode == snf_pkg::OP_IDENT) begin
      byte_resp = address[0] ? device : manufacturer;
    end
  end

  assign byte_load = cmd.take && is_byte && !stat.go_read;

  // frame, latch, busy and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      opcode       <= '0;
      count        <= '0;
      address      <= '0;
      latch        <= 1'b0;
      accepted     <= 1'b0;
      busy         <= '0;
      manufacturer <= snf_pkg::MANUFACTURER_RST;
      device       <= snf_pkg::DEVICE_RST;
      prog_ticks   <= snf_pkg::PROG_TICKS_RST;
      erase_ticks  <= snf_pkg::ERASE_TICKS_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          snf_pkg::REG_MANUFACTURER: manufacturer <= cfg_data[BW-1:0];
          snf_pkg::REG_DEVICE:       device       <= cfg_data[BW-1:0];
          snf_pkg::REG_PROG_TICKS:   prog_ticks   <= cfg_data[snf_pkg::TICK_W-1:0];
          snf_pkg::REG_ERASE_TICKS:  erase_ticks  <= cfg_data[snf_pkg::TICK_W-1:0];
          default: ;
        endcase
      end
      if (cmd.take && is_byte) begin
        if (count == snf_pkg::POS_OPCODE) begin
          opcode   <= mosi_byte;
          accepted <= op_ok;
          count    <= count + 1'b1;
        end else begin
          if (count != snf_pkg::POS_MAX) count <= count + 1'b1;
          // address bytes, then address stepping
          if (addr_op) begin
            if (!data_pos) begin
              address <= {address[FW-BW-1:0], mosi_byte};
            end else if (opcode == snf_pkg::OP_READ || opcode == snf_pkg::OP_IDENT) begin
              address <= address + 1'b1;
            end else if (opcode == snf_pkg::OP_PROGRAM) begin
              address <= {address[FW-1:PAGE_BITS], address[PAGE_BITS-1:0] + 1'b1};
            end
          end
        end
      end else if (cmd.take && is_release) begin
        if (accepted) begin
          if (opcode == snf_pkg::OP_WREN) begin
            latch <= 1'b1;
          end else if (opcode == snf_pkg::OP_PROGRAM && data_pos) begin
            latch <= 1'b0;
            busy  <= prog_ticks;
          end else if (opcode == snf_pkg::OP_ERASE && data_pos) begin
            latch <= 1'b0;
            busy  <= erase_ticks;
          end
        end
        opcode   <= '0;
        count    <= '0;
        address  <= '0;
        accepted <= 1'b0;
      end else if (cmd.take && is_tick) begin
        if (busy_now) busy <= busy - 1'b1;
      end
    end
  end

  // array operands captured with the item
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mem_addr   <= address[ADDR_BITS-1:0];
      prog_byte  <= mosi_byte;
      erase_base <= address[ADDR_BITS-1:SECT_BITS];
    end
  end

  // sweep counter for clearing and erase
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.clr_wr || cmd.ers_wr) begin
      sweep_cnt <= stat.sweep_last ? '0 : sweep_cnt + 1'b1;
    end
  end

  // array write port
  always_comb begin
    ram_we    = cmd.prog_wr || cmd.clr_wr || cmd.ers_wr;
    ram_wdata = snf_pkg::BYTE_IDLE;
    ram_waddr = sweep_cnt;
    if (cmd.prog_wr) begin
      ram_waddr = mem_addr;
      ram_wdata = ram_rdata & prog_byte;
    end else if (cmd.ers_wr) begin
      ram_waddr = {erase_base, sweep_cnt[SECT_BITS-1:0]};
    end
  end

  snf_ram #(
    .WIDTH (BW),
    .DEPTH (DEPTH)
  ) u_array (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (address[ADDR_BITS-1:0]),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (byte_load || cmd.rd_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_load) begin
      miso_byte <= byte_resp;
    end else if (cmd.rd_done) begin
      miso_byte <= ram_rdata;
    end
  end

endmodule

// ===== src/spi_nor_flash_device_model.sv =====
// top level of the serial nor flash device model
//
//  channel   dir  payload                          handshake
//  item_in   in   command[1:0], mosi_byte[7:0]     valid/ready
//  item_out  out  miso_byte[7:0]                   valid/ready
//  cfg       in   cfg_index[1:0], cfg_data[19:0]   cfg_we, no wait
//
// most items are taken in idle and need no further state; read and program data
// bytes then pass through the read or program state (registered array read). a
// release that ends an erase passes into the erase state, one sector write per
// cycle. after reset the array is cleared to 0xFF before the first item is taken.
// a waiting result blocks new items only until it is taken in the same cycle.
module spi_nor_flash_device_model #(
  parameter int unsigned ADDR_BITS    = snf_pkg::ADDR_BITS_DEF,
  parameter int unsigned PAGE_BYTES   = snf_pkg::PAGE_BYTES_DEF,
  parameter int unsigned SECTOR_BYTES = snf_pkg::SECTOR_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  snf_in_if.sink                          item_in,
  snf_out_if.source                       item_out,
  input  logic                            cfg_we,
  input  logic [snf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [snf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  snf_pkg::snf_cmd_t  cmd;
  snf_pkg::snf_stat_t stat;

  // controller
  snf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (item_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  snf_dp #(
    .ADDR_BITS    (ADDR_BITS),
    .PAGE_BYTES   (PAGE_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .command   (item_in.command),
    .mosi_byte (item_in.mosi_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (item_out.ready),
    .out_valid (item_out.valid),
    .miso_byte (item_out.miso_byte)
  );

endmodule
